// ----- hdl/ppss_pkg.sv -----
package ppss_pkg;

  localparam int MAX_POINTS   = 256;
  localparam int CORDIC_STEPS = 16;
  localparam int STEP_LIMIT   = 24;
  localparam int CORDIC_RUN   = (CORDIC_STEPS < STEP_LIMIT) ? CORDIC_STEPS : STEP_LIMIT;
  localparam int IDX_W        = $clog2(MAX_POINTS);
  localparam int CNT_W        = $clog2(MAX_POINTS + 1);
  localparam int ITER_W       = $clog2(STEP_LIMIT);
  localparam int STOP_POINTS  = 5;

  localparam logic signed [15:0] STOP_ACCEL = -16'sd2560;
  localparam logic signed [44:0] CORDIC_K   = 45'sd652032874;
  localparam logic signed [44:0] Q30_ONE    = 45'sd1073741824;
  localparam logic signed [34:0] QUARTER    = 35'sd1073741824;
  localparam logic signed [44:0] NORM_LIMIT = 45'sd1099511627776;

  typedef enum logic [2:0] {
    CFG_LOOKAHEAD_GAIN = 3'd0,
    CFG_LOOKAHEAD_MIN  = 3'd1,
    CFG_SPEED_GAIN     = 3'd2,
    CFG_USE_EXT_SPEED  = 3'd3,
    CFG_EXT_SPEED      = 3'd4,
    CFG_WHEEL_BASE     = 3'd5
  } ppss_cfg_idx_t;

  typedef struct packed {
    logic               cmd;
    logic               first_point;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [15:0] speed;
    logic signed [15:0] heading;
  } ppss_in_t;

  typedef struct packed {
    logic signed [15:0] velocity_cmd;
    logic signed [15:0] accel_cmd;
    logic signed [15:0] steer_angle;
    logic               goal_reached;
  } ppss_out_t;

  // arctangent of 2^-i in 2*pi/2^32 units
  function automatic logic [29:0] cordic_atan(input logic [ITER_W-1:0] i);
    logic [29:0] a;
    case (i)
      5'd0:    a = 30'd536870912;
      5'd1:    a = 30'd316933406;
      5'd2:    a = 30'd167458907;
      5'd3:    a = 30'd85004756;
      5'd4:    a = 30'd42667331;
      5'd5:    a = 30'd21354465;
      5'd6:    a = 30'd10679838;
      5'd7:    a = 30'd5340245;
      5'd8:    a = 30'd2670163;
      5'd9:    a = 30'd1335087;
      5'd10:   a = 30'd667544;
      5'd11:   a = 30'd333772;
      5'd12:   a = 30'd166886;
      5'd13:   a = 30'd83443;
      5'd14:   a = 30'd41722;
      5'd15:   a = 30'd20861;
      5'd16:   a = 30'd10430;
      5'd17:   a = 30'd5215;
      5'd18:   a = 30'd2608;
      5'd19:   a = 30'd1304;
      5'd20:   a = 30'd652;
      5'd21:   a = 30'd326;
      5'd22:   a = 30'd163;
      5'd23:   a = 30'd81;
      default: a = 30'd0;
    endcase
    return a;
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [65:0] v);
    logic signed [15:0] r;
    if (v > 66'sd32767) r = 16'sd32767;
    else if (v < -66'sd32768) r = -16'sd32768;
    else r = 16'(v);
    return r;
  endfunction

endpackage

// ----- hdl/pure_pursuit_steering_speed_core.sv -----
// Channel  Direction  Handshake           Payload
// in       input      in_valid/in_stall   ppss_in_t  (append point or odometry item)
// out      output     out_valid/out_stall ppss_out_t (one command per odometry item)
// cfg      input      cfg_valid/cfg_ready cfg_index 3 bit, cfg_data 24 bit
//
// An append item is taken while the core is idle and does not raise in_stall. An odometry item
// walks all stored points for the nearest one (S_D_SQX, S_D_SQY, S_D_CMP per point), then
// walks on from it for the lookahead point, and makes up to four CORDIC runs with a normalize
// step before each atan2, using the single shared multiplier and CORDIC unit. A short store goes straight to S_DONE.
// Reset (rst_n low, synchronous) empties the store and loads register defaults.
// in_stall is high while an odometry item is at work or its command waits for out.
module pure_pursuit_steering_speed_core
  import ppss_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  ppss_in_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output ppss_out_t out_data,
  input  logic      cfg_valid,
  output logic      cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [23:0] cfg_data
);

  typedef enum logic [24:0] {
    S_IDLE    = 25'd1 << 0,
    S_D_RD    = 25'd1 << 1,
    S_D_SQX   = 25'd1 << 2,
    S_D_SQY   = 25'd1 << 3,
    S_D_CMP   = 25'd1 << 4,
    S_A_RD    = 25'd1 << 5,
    S_A_VT    = 25'd1 << 6,
    S_A_ACC   = 25'd1 << 7,
    S_A_LA    = 25'd1 << 8,
    S_A_L     = 25'd1 << 9,
    S_A_L2    = 25'd1 << 10,
    S_A_L2R   = 25'd1 << 11,
    S_SC_RUN  = 25'd1 << 12,
    S_SC_END  = 25'd1 << 13,
    S_R_X     = 25'd1 << 14,
    S_R_Y     = 25'd1 << 15,
    S_R_D     = 25'd1 << 16,
    S_T_RD    = 25'd1 << 17,
    S_T_INIT  = 25'd1 << 18,
    S_AT_NORM = 25'd1 << 19,
    S_AT_RUN  = 25'd1 << 20,
    S_AT_END  = 25'd1 << 21,
    S_N_MUL   = 25'd1 << 22,
    S_N_NUM   = 25'd1 << 23,
    S_DONE    = 25'd1 << 24
  } state_t;

  state_t state_r, state_nxt;

  // configuration
  logic [15:0]        la_gain_r;
  logic [23:0]        la_min_r;
  logic [15:0]        sp_gain_r;
  logic               use_ext_r;
  logic signed [15:0] ext_spd_r;
  logic [19:0]        wb_r;

  // point store
  logic signed [31:0] mem_x [MAX_POINTS];
  logic signed [31:0] mem_y [MAX_POINTS];
  logic signed [15:0] mem_s [MAX_POINTS];
  logic [CNT_W-1:0]   cnt_r;
  logic signed [31:0] rd_x_r, rd_y_r;
  logic signed [15:0] rd_s_r;
  logic [IDX_W-1:0]   rd_addr;
  logic [IDX_W-1:0]   wr_idx;
  logic               wr_en;

  // item and working registers
  logic signed [31:0] px_r, py_r;
  logic signed [15:0] spd_r, hdg_r;
  logic signed [34:0] refx_r, refy_r;
  logic [IDX_W-1:0]   idx_r, near_r, look_r;
  logic               walk2_r, stop_r, phase_r;
  logic [31:0]        ay_r;
  logic               sat_r;
  logic [63:0]        sq_r, best_r, l2_r;
  logic signed [15:0] vt_r, acc_r, steer_r;
  logic signed [33:0] la_r;
  logic signed [31:0] c_r, s_r;
  logic signed [65:0] prod_r;
  logic signed [32:0] mul_a, mul_b;

  // CORDIC unit
  logic signed [44:0] cx_r, cy_r;
  logic signed [34:0] cz_r;
  logic [ITER_W-1:0]  it_r;
  logic               rot_r, flip_r, at_zero_r;

  ppss_out_t out_data_r;
  logic      out_valid_r;

  logic in_fire, cfg_fire, out_load;
  assign in_stall  = (state_r != S_IDLE);
  assign in_fire   = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid && cfg_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign out_load  = (state_r == S_DONE) && (!out_valid_r || !out_stall);

  // append: a first point restarts the store; drop points beyond a full store
  assign wr_idx = in_data.first_point ? '0 : cnt_r[IDX_W-1:0];
  assign wr_en  = in_fire && !in_data.cmd &&
                  (in_data.first_point || cnt_r < CNT_W'(MAX_POINTS));

  // distance to the reference point (vehicle or rear axle)
  logic signed [35:0] dx, dy;
  logic [35:0]        ax, ay;
  logic [64:0]        dsum;
  logic [63:0]        d_cur;
  logic               last_pt, take_near, far_pt, stop_cond;
  logic [IDX_W-1:0]   near_fin;

  assign dx = 36'(rd_x_r) - 36'(refx_r);
  assign dy = 36'(rd_y_r) - 36'(refy_r);
  assign ax = dx[35] ? 36'(-dx) : 36'(dx);
  assign ay = dy[35] ? 36'(-dy) : 36'(dy);
  assign dsum  = {1'b0, sq_r} + {1'b0, prod_r[63:0]};
  assign d_cur = (sat_r || dsum[64]) ? '1 : dsum[63:0];

  assign last_pt   = (CNT_W'(idx_r) == cnt_r - CNT_W'(1));
  assign take_near = (idx_r == '0) || (d_cur < best_r);
  assign near_fin  = take_near ? idx_r : near_r;
  assign stop_cond = (CNT_W'(near_fin) + CNT_W'(1) == cnt_r);
  assign far_pt    = la_r[33] || (la_r == '0) || (d_cur >= l2_r);

  // CORDIC step: rotation drives z to zero, vectoring drives y to zero
  logic signed [44:0] xs, ys;
  logic signed [34:0] at_w;
  logic               sigma, it_last;
  assign xs      = cx_r >>> it_r;
  assign ys      = cy_r >>> it_r;
  assign at_w    = $signed({5'b0, cordic_atan(it_r)});
  assign sigma   = rot_r ? !cz_r[34] : cy_r[44];
  assign it_last = (it_r == ITER_W'(CORDIC_RUN - 1));

  // atan2 result and rounding to 2*pi/65536 units
  logic signed [34:0] zr;
  logic signed [15:0] at_ang;
  assign zr     = (cz_r + 35'sd32768) >>> 16;
  assign at_ang = at_zero_r ? 16'sd0 : sat16(66'(zr));

  // sin/cos seed: fold the angle into the right half plane
  logic signed [15:0] sc_ang;
  logic [31:0]        ua, ua2;
  logic               sc_flip;
  assign sc_ang  = (state_r == S_AT_END) ? 16'(at_ang - hdg_r) : hdg_r;
  assign ua      = {sc_ang, 16'h0000};
  assign sc_flip = (ua > 32'h4000_0000) && (ua < 32'hC000_0000);
  assign ua2     = sc_flip ? ua - 32'h8000_0000 : ua;

  // atan2 seed: rotate the left half plane by a quarter turn
  logic signed [44:0] at_xi, at_yi, at_x0, at_y0;
  logic signed [34:0] at_z0;
  logic               at_zero;
  always_comb begin
    if (state_r == S_T_INIT) begin
      at_xi = 45'(dx);
      at_yi = 45'(dy);
    end else begin
      at_xi = 45'(la_r);
      at_yi = 45'(prod_r >>> 29);
    end
    at_zero = (at_xi == '0) && (at_yi == '0);
    at_x0   = at_xi;
    at_y0   = at_yi;
    at_z0   = '0;
    if (at_xi[44]) begin
      if (!at_yi[44]) begin
        at_x0 = at_yi;
        at_y0 = -at_xi;
        at_z0 = QUARTER;
      end else begin
        at_x0 = -at_yi;
        at_y0 = at_xi;
        at_z0 = -QUARTER;
      end
    end
  end

  // clamp CORDIC sin/cos to +-1.0 in Q2.30
  logic signed [44:0] cx_c, cy_c;
  assign cx_c = (cx_r > Q30_ONE) ? Q30_ONE : ((cx_r < -Q30_ONE) ? -Q30_ONE : cx_r);
  assign cy_c = (cy_r > Q30_ONE) ? Q30_ONE : ((cy_r < -Q30_ONE) ? -Q30_ONE : cy_r);

  logic at_norm_go;
  logic signed [44:0] abs_cy;
  assign abs_cy     = cy_r[44] ? -cy_r : cy_r;
  assign at_norm_go = (cx_r < NORM_LIMIT) && (abs_cy < NORM_LIMIT);

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      S_D_SQX: begin
        mul_a = $signed({1'b0, ax[31:0]});
        mul_b = $signed({1'b0, ax[31:0]});
      end
      S_D_SQY: begin
        mul_a = $signed({1'b0, ay_r});
        mul_b = $signed({1'b0, ay_r});
      end
      S_A_ACC: begin
        mul_a = $signed(33'(sp_gain_r));
        mul_b = 33'(17'(vt_r) - 17'(spd_r));
      end
      S_A_LA: begin
        mul_a = $signed(33'(la_gain_r));
        mul_b = 33'(vt_r);
      end
      S_A_L2: begin
        mul_a = la_r[32:0];
        mul_b = la_r[32:0];
      end
      S_R_X: begin
        mul_a = $signed(33'(wb_r));
        mul_b = 33'(c_r);
      end
      S_R_Y, S_N_MUL: begin
        mul_a = $signed(33'(wb_r));
        mul_b = 33'(s_r);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // read address: prefetch the next point while the current one finishes
  always_comb begin
    case (state_r)
      S_D_SQY, S_D_CMP: rd_addr = IDX_W'(idx_r + 1'b1);
      S_A_RD:           rd_addr = near_r;
      S_T_RD:           rd_addr = look_r;
      default:          rd_addr = idx_r;
    endcase
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:    if (in_fire && in_data.cmd) begin
                   state_nxt = (cnt_r <= CNT_W'(STOP_POINTS)) ? S_DONE : S_D_RD;
                 end
      S_D_RD:    state_nxt = S_D_SQX;
      S_D_SQX:   state_nxt = S_D_SQY;
      S_D_SQY:   state_nxt = S_D_CMP;
      S_D_CMP:   begin
                   if (!walk2_r) begin
                     if (last_pt) state_nxt = stop_cond ? S_DONE : S_A_RD;
                     else state_nxt = S_D_SQX;
                   end else begin
                     state_nxt = (far_pt || last_pt) ? S_T_RD : S_D_SQX;
                   end
                 end
      S_A_RD:    state_nxt = S_A_VT;
      S_A_VT:    state_nxt = S_A_ACC;
      S_A_ACC:   state_nxt = S_A_LA;
      S_A_LA:    state_nxt = S_A_L;
      S_A_L:     state_nxt = S_A_L2;
      S_A_L2:    state_nxt = S_A_L2R;
      S_A_L2R:   state_nxt = S_SC_RUN;
      S_SC_RUN:  if (it_last) state_nxt = S_SC_END;
      S_SC_END:  state_nxt = phase_r ? S_N_MUL : S_R_X;
      S_R_X:     state_nxt = S_R_Y;
      S_R_Y:     state_nxt = S_R_D;
      S_R_D:     state_nxt = S_D_RD;
      S_T_RD:    state_nxt = S_T_INIT;
      S_T_INIT:  state_nxt = at_zero ? S_AT_END : S_AT_NORM;
      S_AT_NORM: if (!at_norm_go) state_nxt = S_AT_RUN;
      S_AT_RUN:  if (it_last) state_nxt = S_AT_END;
      S_AT_END:  state_nxt = phase_r ? S_DONE : S_SC_RUN;
      S_N_MUL:   state_nxt = S_N_NUM;
      S_N_NUM:   state_nxt = at_zero ? S_AT_END : S_AT_NORM;
      S_DONE:    if (out_load) state_nxt = S_IDLE;
      default:   state_nxt = S_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      la_gain_r   <= 16'd256;
      la_min_r    <= 24'd131072;
      sp_gain_r   <= 16'd256;
      use_ext_r   <= 1'b0;
      ext_spd_r   <= 16'sd0;
      wb_r        <= 20'd182845;
    end else begin
      state_r <= state_nxt;
      if (wr_en) cnt_r <= CNT_W'(wr_idx) + CNT_W'(1);
      if (out_load) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
      if (cfg_fire) begin
        case (cfg_index)
          CFG_LOOKAHEAD_GAIN: la_gain_r <= cfg_data[15:0];
          CFG_LOOKAHEAD_MIN:  la_min_r  <= cfg_data;
          CFG_SPEED_GAIN:     sp_gain_r <= cfg_data[15:0];
          CFG_USE_EXT_SPEED:  use_ext_r <= cfg_data[0];
          CFG_EXT_SPEED:      ext_spd_r <= $signed(cfg_data[15:0]);
          CFG_WHEEL_BASE:     wb_r      <= cfg_data[19:0];
          default: ;
        endcase
      end
    end
  end

  // point store
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_x[wr_idx] <= in_data.pos_x;
      mem_y[wr_idx] <= in_data.pos_y;
      mem_s[wr_idx] <= in_data.speed;
    end
    rd_x_r <= mem_x[rd_addr];
    rd_y_r <= mem_y[rd_addr];
    rd_s_r <= mem_s[rd_addr];
  end

  // datapath
  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
    case (state_r)
      S_IDLE: begin
        if (in_fire && in_data.cmd) begin
          px_r    <= in_data.pos_x;
          py_r    <= in_data.pos_y;
          spd_r   <= in_data.speed;
          hdg_r   <= in_data.heading;
          refx_r  <= 35'(in_data.pos_x);
          refy_r  <= 35'(in_data.pos_y);
          idx_r   <= '0;
          near_r  <= '0;
          walk2_r <= 1'b0;
          stop_r  <= (cnt_r <= CNT_W'(STOP_POINTS));
        end
      end
      S_D_SQX: begin
        ay_r  <= ay[31:0];
        sat_r <= (ax[35:32] != '0) || (ay[35:32] != '0);
      end
      S_D_SQY: sq_r <= prod_r[63:0];
      S_D_CMP: begin
        if (!walk2_r) begin
          if (take_near) best_r <= d_cur;
          near_r <= near_fin;
          if (last_pt) stop_r <= stop_cond;
        end else begin
          look_r <= idx_r;
        end
        idx_r <= IDX_W'(idx_r + 1'b1);
      end
      S_A_VT:  vt_r <= use_ext_r ? ext_spd_r : rd_s_r;
      S_A_LA:  acc_r <= sat16(prod_r >>> 8);
      S_A_L:   la_r <= 34'(prod_r) + 34'(la_min_r);
      S_A_L2R: begin
        l2_r    <= prod_r[63:0];
        phase_r <= 1'b0;
        cx_r    <= CORDIC_K;
        cy_r    <= '0;
        cz_r    <= 35'($signed(ua2));
        flip_r  <= sc_flip;
        rot_r   <= 1'b1;
        it_r    <= '0;
      end
      S_SC_RUN, S_AT_RUN: begin
        if (sigma) begin
          cx_r <= cx_r - ys;
          cy_r <= cy_r + xs;
          cz_r <= cz_r - at_w;
        end else begin
          cx_r <= cx_r + ys;
          cy_r <= cy_r - xs;
          cz_r <= cz_r + at_w;
        end
        it_r <= ITER_W'(it_r + 1'b1);
      end
      S_SC_END: begin
        c_r <= flip_r ? 32'(-cx_c) : 32'(cx_c);
        s_r <= flip_r ? 32'(-cy_c) : 32'(cy_c);
      end
      S_R_Y:   refx_r <= 35'(px_r) - 35'(prod_r >>> 31);
      S_R_D: begin
        refy_r  <= 35'(py_r) - 35'(prod_r >>> 31);
        idx_r   <= near_r;
        walk2_r <= 1'b1;
      end
      S_T_INIT, S_N_NUM: begin
        cx_r      <= at_x0;
        cy_r      <= at_y0;
        cz_r      <= at_z0;
        at_zero_r <= at_zero;
        rot_r     <= 1'b0;
        it_r      <= '0;
      end
      S_AT_NORM: begin
        // scale up small vectors so the CORDIC keeps its precision
        if (at_norm_go) begin
          cx_r <= cx_r <<< 1;
          cy_r <= cy_r <<< 1;
        end
        it_r <= '0;
      end
      S_AT_END: begin
        if (phase_r) begin
          steer_r <= at_ang;
        end else begin
          // heading error alpha seeds the second sin/cos run
          phase_r <= 1'b1;
          cx_r    <= CORDIC_K;
          cy_r    <= '0;
          cz_r    <= 35'($signed(ua2));
          flip_r  <= sc_flip;
          rot_r   <= 1'b1;
          it_r    <= '0;
        end
      end
      S_DONE: begin
        if (out_load) begin
          if (stop_r) begin
            out_data_r.velocity_cmd <= 16'sd0;
            out_data_r.accel_cmd    <= STOP_ACCEL;
            out_data_r.steer_angle  <= 16'sd0;
            out_data_r.goal_reached <= 1'b1;
          end else begin
            out_data_r.velocity_cmd <= vt_r;
            out_data_r.accel_cmd    <= acc_r;
            out_data_r.steer_angle  <= steer_r;
            out_data_r.goal_reached <= 1'b0;
          end
        end
      end
      default: ;
    endcase
  end

endmodule
